// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // queue geometry
  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned CntOutW = 5;

  // operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded max-priority queue kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_stall_o) carries one request: op_i selects
//   insert of item_value_i or removal of the largest entry.
//   output channel (out_valid_o / out_stall_i) returns one result per
//   request: removed value, status and the entry count after the request.
//   A request accepted at an edge has its result on the output register
//   from the next cycle on. Throughput is one request per cycle while the
//   output is not stalled; every cell compares and shifts in the same cycle,
//   so the chain length does not affect rate.
//   Equal values: the newest insert sits ahead and leaves first.
//   Insert into a full queue is dropped with status full; remove from an
//   empty queue returns zero with status empty.
//   Reset empties the queue (count to zero) and drops any pending result.
//   While the receiver stalls a held result, in_stall_o is raised and no
//   request is taken; a free output register lets requests flow every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic [DataW-1:0] item_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [DataW-1:0]      removed_value_o,
  output logic [1:0]            status_o,
  output logic [CntOutW-1:0]    entry_count_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic [DataW-1:0]  removed_q, removed_d;
  spq_status_e       status_q, status_d;
  logic [31:0]       count_ext;
  logic              in_accept;
  logic              is_full, is_empty;
  spq_cmd_t          cmd;

  logic [DataW-1:0]  cell_value [Depth];
  logic              cell_ins   [Depth];
  logic              cell_valid [Depth];

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CountW'(Depth));
  assign is_empty = (count_q == '0);

  // command to the chain
  assign cmd.do_insert = in_accept && (op_i == OpInsert) && !is_full;
  assign cmd.do_remove = in_accept && (op_i == OpRemove) && !is_empty;

  // chain of cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] left_value, right_value;
    logic             left_ins;

    assign cell_valid[i] = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_value = item_value_i;
      assign left_ins   = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .new_value_i   (item_value_i),
      .valid_i       (cell_valid[i]),
      .left_value_i  (left_value),
      .left_ins_i    (left_ins),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .ins_here_o    (cell_ins[i])
    );
  end

  // count and result
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    status_d  = ST_OK;
    if (op_i == OpInsert) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d   = count_q - CountW'(1);
        removed_d = cell_value[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  assign count_ext       = 32'(count_q);
  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign entry_count_o   = count_ext[CntOutW-1:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count above depth");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_insert |=> count_q == $past(count_q) + CountW'(1))
    else $error("insert did not grow the count");

  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_remove |=> out_valid_o && removed_value_o == $past(cell_value[0]))
    else $error("remove did not return the head entry");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> removed_value_o == '0)
    else $error("failed request returned a nonzero value");
`endif

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds one entry, takes the new value, its
// left neighbor's entry on insert, or its right neighbor's entry on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire spq_cmd_t         cmd_i,
  input  wire logic [DataW-1:0] new_value_i,
  input  wire logic             valid_i,
  input  wire logic [DataW-1:0] left_value_i,
  input  wire logic             left_ins_i,
  input  wire logic [DataW-1:0] right_value_i,
  output logic [DataW-1:0]      value_o,
  output logic                  ins_here_o
);

  logic [DataW-1:0] value_q, value_d;

  // new value belongs at or ahead of this slot
  assign ins_here_o = !valid_i || ($signed(new_value_i) >= $signed(value_q));

  // next entry of this slot
  always_comb begin
    value_d = value_q;
    if (cmd_i.do_insert) begin
      if (left_ins_i) begin
        value_d = left_value_i;
      end else if (ins_here_o) begin
        value_d = new_value_i;
      end
    end else if (cmd_i.do_remove) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire
